### hw/rtl/assert_macros.svh
// Assertion shorthands shared by the RTL. Every macro samples on the rising
// edge of aclk and is disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every sampled edge.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/tlsr_pkg.sv
package tlsr_pkg;

    localparam int COORD_BITS   = 16;
    localparam int PEN_BITS     = 8;
    localparam int CFG_BITS     = 13;
    localparam int CFG_IDX_BITS = 1;
    localparam int OUT_BITS     = 12;
    localparam int STEP_BITS    = 16;

    // Block corners reach half a pen beyond the coordinate range.
    localparam int BLK_BITS = ((COORD_BITS > PEN_BITS) ? COORD_BITS : PEN_BITS) + 2;
    localparam int ERR_BITS = COORD_BITS + 3;

    // Step guard is (width + height) * 4 + 8.
    localparam int GUARD_SHIFT = 2;
    localparam int GUARD_BIAS  = 8;

    localparam int RST_WIDTH  = 640;
    localparam int RST_HEIGHT = 480;

    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = 2;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] REG_SURFACE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SURFACE_HEIGHT = 1'd1;

    typedef logic signed [BLK_BITS-1:0] blk_coord_t;

    typedef struct packed {
        logic                         mode;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic [PEN_BITS-1:0]          pen_size;
    } tlsr_in_t;

    typedef struct packed {
        logic                rect_valid;
        logic [OUT_BITS-1:0] rect_left;
        logic [OUT_BITS-1:0] rect_top;
        logic [OUT_BITS-1:0] rect_right;
        logic [OUT_BITS-1:0] rect_bottom;
        logic                last_of_step;
        logic                line_done;
    } tlsr_out_t;

endpackage

### hw/rtl/thick_line_strip_rasterizer_top.sv
// Thick line rasterizer: walks a square pen along a Bresenham line and hands
// out the rectangles of surface pixels that the pen newly covers.
// Input channel (s_valid/s_ready/s_data): a load beat (mode 0) latches the
// endpoints and pen size and produces nothing; a step beat (mode 1) moves
// the pen and produces one or two rectangles, or none once the line is done.
// Result channel (m_valid/m_ready/m_data): one rectangle per beat, in order,
// last_of_step marking the final rectangle of a step, line_done set on the
// rectangles of the step that ended the line.
// Configuration: cfg_we writes cfg_wdata into surface width (index 0) or
// surface height (index 1) at once; write only while the block is idle.
// Timing: a step beat is worked out in the cycle it is accepted; its rectangles
// are registered into the result queue behind any earlier ones. A beat is
// accepted in any cycle in which the four-entry result queue has room for two
// rectangles. With results draining at one per clock, steps of one rectangle
// flow at one beat per clock; steps of two rectangles make s_ready drop at times.
// When the receiver stalls the queue fills and s_ready drops; nothing is lost.
// Reset (aresetn low at a clock edge) empties the queue, marks no line as
// loaded and restores the 640 x 480 surface.
`include "assert_macros.svh"

module thick_line_strip_rasterizer_top #(
    parameter int MAX_DIM = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [tlsr_pkg::CFG_IDX_BITS-1:0]   cfg_addr,
    input  logic [tlsr_pkg::CFG_BITS-1:0]       cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  tlsr_pkg::tlsr_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output tlsr_pkg::tlsr_out_t                 m_data
);
    import tlsr_pkg::*;

    localparam int DIM_BITS   = $clog2(MAX_DIM + 1);
    localparam int EXT_BITS   = (CFG_BITS > DIM_BITS) ? CFG_BITS : DIM_BITS;
    localparam int LIM_BITS   = DIM_BITS + 1;
    localparam int CMP_BITS   = (BLK_BITS > LIM_BITS) ? BLK_BITS : LIM_BITS;
    localparam int GUARD_BITS = DIM_BITS + GUARD_SHIFT + 1;
    localparam int GCMP_BITS  = (GUARD_BITS > STEP_BITS) ? GUARD_BITS : STEP_BITS;
    localparam int RST_W_EFF  = (RST_WIDTH > MAX_DIM) ? MAX_DIM : RST_WIDTH;
    localparam int RST_H_EFF  = (RST_HEIGHT > MAX_DIM) ? MAX_DIM : RST_HEIGHT;
    localparam int RST_GUARD_M1 =
        ((RST_W_EFF + RST_H_EFF) << GUARD_SHIFT) + GUARD_BIAS - 1;

    function automatic logic [DIM_BITS-1:0] eff_dim(input logic [CFG_BITS-1:0] v);
        logic [EXT_BITS-1:0] ve;
        ve = EXT_BITS'(v);
        if (ve > EXT_BITS'(MAX_DIM)) begin
            eff_dim = DIM_BITS'(MAX_DIM);
        end else begin
            eff_dim = DIM_BITS'(ve);
        end
    endfunction

    function automatic logic [GUARD_BITS-1:0] guard_m1(input logic [DIM_BITS-1:0] w,
                                                       input logic [DIM_BITS-1:0] h);
        logic [GUARD_BITS-1:0] s;
        s = GUARD_BITS'(w) + GUARD_BITS'(h);
        guard_m1 = (s << GUARD_SHIFT) + GUARD_BITS'(GUARD_BIAS - 1);
    endfunction

    function automatic logic signed [LIM_BITS-1:0] last_index(input logic [DIM_BITS-1:0] d);
        last_index = $signed({1'b0, d}) - LIM_BITS'(1);
    endfunction

    function automatic tlsr_out_t clip_rect(input blk_coord_t x0, input blk_coord_t y0,
                                            input blk_coord_t x1, input blk_coord_t y1,
                                            input logic signed [LIM_BITS-1:0] xm,
                                            input logic signed [LIM_BITS-1:0] ym);
        logic signed [CMP_BITS-1:0] l;
        logic signed [CMP_BITS-1:0] t;
        logic signed [CMP_BITS-1:0] r;
        logic signed [CMP_BITS-1:0] b;
        tlsr_out_t                  o;
        l = CMP_BITS'(x0);
        t = CMP_BITS'(y0);
        r = CMP_BITS'(x1);
        b = CMP_BITS'(y1);
        if (l < 0) begin
            l = '0;
        end
        if (t < 0) begin
            t = '0;
        end
        if (r > CMP_BITS'(xm)) begin
            r = CMP_BITS'(xm);
        end
        if (b > CMP_BITS'(ym)) begin
            b = CMP_BITS'(ym);
        end
        o = '0;
        if (l <= r && t <= b) begin
            o.rect_valid  = 1'b1;
            o.rect_left   = l[OUT_BITS-1:0];
            o.rect_top    = t[OUT_BITS-1:0];
            o.rect_right  = r[OUT_BITS-1:0];
            o.rect_bottom = b[OUT_BITS-1:0];
        end
        clip_rect = o;
    endfunction

    // Surface configuration, kept in the clamped forms the datapath uses.
    logic [DIM_BITS-1:0]          wd_reg, wd_next;
    logic [DIM_BITS-1:0]          hd_reg, hd_next;
    logic signed [LIM_BITS-1:0]   xmax_reg, xmax_next;
    logic signed [LIM_BITS-1:0]   ymax_reg, ymax_next;
    logic [GUARD_BITS-1:0]        guard_m1_reg, guard_m1_next;

    // Line walker state.
    logic signed [COORD_BITS-1:0] pen_col_reg, pen_col_next;
    logic signed [COORD_BITS-1:0] pen_row_reg, pen_row_next;
    logic signed [COORD_BITS-1:0] target_col_reg, target_col_next;
    logic signed [COORD_BITS-1:0] target_row_reg, target_row_next;
    blk_coord_t                   bx0_reg, bx0_next;
    blk_coord_t                   by0_reg, by0_next;
    blk_coord_t                   bx1_reg, bx1_next;
    blk_coord_t                   by1_reg, by1_next;
    logic signed [ERR_BITS-1:0]   err_reg, err_next;
    logic [COORD_BITS:0]          span_x_reg, span_x_next;
    logic signed [COORD_BITS+1:0] span_y_neg_reg, span_y_neg_next;
    logic                         neg_x_reg, neg_x_next;
    logic                         neg_y_reg, neg_y_next;
    logic                         thick_gt1_reg, thick_gt1_next;
    logic                         have_prev_reg, have_prev_next;
    logic                         moved_x_reg, moved_x_next;
    logic                         moved_y_reg, moved_y_next;
    logic                         finished_reg, finished_next;
    logic [STEP_BITS-1:0]         steps_reg, steps_next;

    // Result queue.
    tlsr_out_t                    fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0]     head_reg, head_next;
    logic [FIFO_PTR_BITS-1:0]     tail_reg, tail_next;
    logic [FIFO_PTR_BITS:0]       count_reg, count_next;

    logic                         s_fire;
    logic                         pop;
    logic                         step_go;
    logic                         step_done;
    logic [1:0]                   n_rect;
    logic [1:0]                   n_push;
    tlsr_out_t                    res0;
    tlsr_out_t                    res1;

    // Load datapath.
    logic [PEN_BITS-1:0]          ld_thick;
    logic signed [PEN_BITS:0]     ld_half;
    logic signed [PEN_BITS:0]     ld_reach;
    logic signed [COORD_BITS:0]   ld_dx;
    logic signed [COORD_BITS:0]   ld_dy;
    logic signed [COORD_BITS:0]   ld_adx;
    logic signed [COORD_BITS+1:0] ld_dyneg;

    // Step datapath.
    logic signed [ERR_BITS:0]     e2;
    logic signed [ERR_BITS:0]     sx_wide;
    logic signed [ERR_BITS:0]     sy_wide;
    logic                         cx;
    logic                         cy;
    logic signed [ERR_BITS-1:0]   add_x;
    logic signed [ERR_BITS-1:0]   add_y;
    blk_coord_t                   col;
    blk_coord_t                   row;
    blk_coord_t                   sx0;
    blk_coord_t                   sx1;
    logic                         has_col;
    logic                         has_row;
    tlsr_out_t                    rect_full;
    tlsr_out_t                    rect_col;
    tlsr_out_t                    rect_row;

    logic                         quiet_beat;
    logic                         m_box_zero;

    assign s_ready = (count_reg <= (FIFO_PTR_BITS+1)'(FIFO_DEPTH - 2));
    assign m_valid = (count_reg != '0);
    assign m_data  = fifo_reg[head_reg];
    assign s_fire  = s_valid && s_ready;
    assign pop     = m_valid && m_ready;
    assign step_go = s_fire && (s_data.mode == MODE_STEP) && !finished_reg;

    assign quiet_beat = s_fire && !step_go;
    assign m_box_zero = (m_data.rect_left == '0) && (m_data.rect_top == '0)
                        && (m_data.rect_right == '0) && (m_data.rect_bottom == '0);

    always_comb begin
        ld_thick = (s_data.pen_size == '0) ? PEN_BITS'(1) : s_data.pen_size;
        ld_half  = $signed({1'b0, ld_thick >> 1});
        ld_reach = $signed({1'b0, (ld_thick - PEN_BITS'(1)) >> 1});
        ld_dx    = (COORD_BITS+1)'(s_data.end_x) - (COORD_BITS+1)'(s_data.start_x);
        ld_dy    = (COORD_BITS+1)'(s_data.end_y) - (COORD_BITS+1)'(s_data.start_y);
        ld_adx   = (ld_dx < 0) ? -ld_dx : ld_dx;
        ld_dyneg = (ld_dy < 0) ? (COORD_BITS+2)'(ld_dy) : -(COORD_BITS+2)'(ld_dy);
    end

    always_comb begin
        e2      = {err_reg, 1'b0};
        sx_wide = (ERR_BITS+1)'($signed({1'b0, span_x_reg}));
        sy_wide = (ERR_BITS+1)'(span_y_neg_reg);
        cx      = (e2 >= sy_wide);
        cy      = (e2 <= sx_wide);
        add_x   = cx ? ERR_BITS'(span_y_neg_reg) : ERR_BITS'(0);
        add_y   = cy ? ERR_BITS'($signed({1'b0, span_x_reg})) : ERR_BITS'(0);

        step_done = ((pen_col_reg == target_col_reg) && (pen_row_reg == target_row_reg))
                    || (GCMP_BITS'(steps_reg) >= GCMP_BITS'(guard_m1_reg));

        // Moves are one pixel, so the new column strip is the block's leading
        // column and the new row strip is its leading row, trimmed to the
        // columns the previous block also covered.
        col = neg_x_reg ? bx0_reg : bx1_reg;
        row = neg_y_reg ? by0_reg : by1_reg;
        sx0 = (moved_x_reg && neg_x_reg) ? bx0_reg + BLK_BITS'(1) : bx0_reg;
        sx1 = (moved_x_reg && !neg_x_reg) ? bx1_reg - BLK_BITS'(1) : bx1_reg;
        has_col = have_prev_reg && moved_x_reg;
        has_row = have_prev_reg && moved_y_reg && (!moved_x_reg || thick_gt1_reg);

        rect_full = clip_rect(bx0_reg, by0_reg, bx1_reg, by1_reg, xmax_reg, ymax_reg);
        rect_col  = clip_rect(col, by0_reg, col, by1_reg, xmax_reg, ymax_reg);
        rect_row  = clip_rect(sx0, row, sx1, row, xmax_reg, ymax_reg);

        if (!have_prev_reg) begin
            res0   = rect_full;
            res1   = rect_row;
            n_rect = 2'd1;
        end else if (has_col) begin
            res0   = rect_col;
            res1   = rect_row;
            n_rect = has_row ? 2'd2 : 2'd1;
        end else begin
            res0   = rect_row;
            res1   = rect_row;
            n_rect = has_row ? 2'd1 : 2'd0;
        end
        res0.last_of_step = (n_rect == 2'd1);
        res1.last_of_step = 1'b1;
        res0.line_done    = step_done;
        res1.line_done    = step_done;
        n_push = step_go ? n_rect : 2'd0;
    end

    always_comb begin
        wd_next         = wd_reg;
        hd_next         = hd_reg;
        xmax_next       = xmax_reg;
        ymax_next       = ymax_reg;
        guard_m1_next   = guard_m1_reg;
        pen_col_next    = pen_col_reg;
        pen_row_next    = pen_row_reg;
        target_col_next = target_col_reg;
        target_row_next = target_row_reg;
        bx0_next        = bx0_reg;
        by0_next        = by0_reg;
        bx1_next        = bx1_reg;
        by1_next        = by1_reg;
        err_next        = err_reg;
        span_x_next     = span_x_reg;
        span_y_neg_next = span_y_neg_reg;
        neg_x_next      = neg_x_reg;
        neg_y_next      = neg_y_reg;
        thick_gt1_next  = thick_gt1_reg;
        have_prev_next  = have_prev_reg;
        moved_x_next    = moved_x_reg;
        moved_y_next    = moved_y_reg;
        finished_next   = finished_reg;
        steps_next      = steps_reg;

        if (cfg_we) begin
            case (cfg_addr)
                REG_SURFACE_WIDTH: begin
                    wd_next       = eff_dim(cfg_wdata);
                    xmax_next     = last_index(eff_dim(cfg_wdata));
                    guard_m1_next = guard_m1(eff_dim(cfg_wdata), hd_reg);
                end
                REG_SURFACE_HEIGHT: begin
                    hd_next       = eff_dim(cfg_wdata);
                    ymax_next     = last_index(eff_dim(cfg_wdata));
                    guard_m1_next = guard_m1(wd_reg, eff_dim(cfg_wdata));
                end
                default: begin
                end
            endcase
        end

        if (s_fire && (s_data.mode == MODE_LOAD)) begin
            pen_col_next    = s_data.start_x;
            pen_row_next    = s_data.start_y;
            target_col_next = s_data.end_x;
            target_row_next = s_data.end_y;
            bx0_next        = BLK_BITS'(s_data.start_x) - BLK_BITS'(ld_half);
            by0_next        = BLK_BITS'(s_data.start_y) - BLK_BITS'(ld_half);
            bx1_next        = BLK_BITS'(s_data.start_x) + BLK_BITS'(ld_reach);
            by1_next        = BLK_BITS'(s_data.start_y) + BLK_BITS'(ld_reach);
            span_x_next     = ld_adx[COORD_BITS:0];
            span_y_neg_next = ld_dyneg;
            err_next        = ERR_BITS'(ld_adx) + ERR_BITS'(ld_dyneg);
            neg_x_next      = !(s_data.start_x < s_data.end_x);
            neg_y_next      = !(s_data.start_y < s_data.end_y);
            thick_gt1_next  = (ld_thick > PEN_BITS'(1));
            have_prev_next  = 1'b0;
            steps_next      = '0;
            finished_next   = 1'b0;
        end else if (step_go) begin
            have_prev_next = 1'b1;
            steps_next     = steps_reg + STEP_BITS'(1);
            if (step_done) begin
                finished_next = 1'b1;
            end else begin
                err_next     = err_reg + add_x + add_y;
                moved_x_next = cx;
                moved_y_next = cy;
                if (cx) begin
                    if (neg_x_reg) begin
                        pen_col_next = pen_col_reg - COORD_BITS'(1);
                        bx0_next     = bx0_reg - BLK_BITS'(1);
                        bx1_next     = bx1_reg - BLK_BITS'(1);
                    end else begin
                        pen_col_next = pen_col_reg + COORD_BITS'(1);
                        bx0_next     = bx0_reg + BLK_BITS'(1);
                        bx1_next     = bx1_reg + BLK_BITS'(1);
                    end
                end
                if (cy) begin
                    if (neg_y_reg) begin
                        pen_row_next = pen_row_reg - COORD_BITS'(1);
                        by0_next     = by0_reg - BLK_BITS'(1);
                        by1_next     = by1_reg - BLK_BITS'(1);
                    end else begin
                        pen_row_next = pen_row_reg + COORD_BITS'(1);
                        by0_next     = by0_reg + BLK_BITS'(1);
                        by1_next     = by1_reg + BLK_BITS'(1);
                    end
                end
            end
        end
    end

    always_comb begin
        head_next  = pop ? head_reg + FIFO_PTR_BITS'(1) : head_reg;
        tail_next  = tail_reg + FIFO_PTR_BITS'(n_push);
        count_next = count_reg + (FIFO_PTR_BITS+1)'(n_push) - (FIFO_PTR_BITS+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wd_reg         <= DIM_BITS'(RST_W_EFF);
            hd_reg         <= DIM_BITS'(RST_H_EFF);
            xmax_reg       <= LIM_BITS'(RST_W_EFF - 1);
            ymax_reg       <= LIM_BITS'(RST_H_EFF - 1);
            guard_m1_reg   <= GUARD_BITS'(RST_GUARD_M1);
            pen_col_reg    <= '0;
            pen_row_reg    <= '0;
            target_col_reg <= '0;
            target_row_reg <= '0;
            bx0_reg        <= '0;
            by0_reg        <= '0;
            bx1_reg        <= '0;
            by1_reg        <= '0;
            err_reg        <= '0;
            span_x_reg     <= '0;
            span_y_neg_reg <= '0;
            neg_x_reg      <= 1'b0;
            neg_y_reg      <= 1'b0;
            thick_gt1_reg  <= 1'b0;
            have_prev_reg  <= 1'b0;
            moved_x_reg    <= 1'b0;
            moved_y_reg    <= 1'b0;
            finished_reg   <= 1'b1;
            steps_reg      <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
        end else begin
            wd_reg         <= wd_next;
            hd_reg         <= hd_next;
            xmax_reg       <= xmax_next;
            ymax_reg       <= ymax_next;
            guard_m1_reg   <= guard_m1_next;
            pen_col_reg    <= pen_col_next;
            pen_row_reg    <= pen_row_next;
            target_col_reg <= target_col_next;
            target_row_reg <= target_row_next;
            bx0_reg        <= bx0_next;
            by0_reg        <= by0_next;
            bx1_reg        <= bx1_next;
            by1_reg        <= by1_next;
            err_reg        <= err_next;
            span_x_reg     <= span_x_next;
            span_y_neg_reg <= span_y_neg_next;
            neg_x_reg      <= neg_x_next;
            neg_y_reg      <= neg_y_next;
            thick_gt1_reg  <= thick_gt1_next;
            have_prev_reg  <= have_prev_next;
            moved_x_reg    <= moved_x_next;
            moved_y_reg    <= moved_y_next;
            finished_reg   <= finished_next;
            steps_reg      <= steps_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            fifo_reg[tail_reg] <= res0;
        end
        if (n_push == 2'd2) begin
            fifo_reg[tail_reg + FIFO_PTR_BITS'(1)] <= res1;
        end
    end

    `ASSERT_ALWAYS(a_queue_bound, count_reg <= (FIFO_PTR_BITS+1)'(FIFO_DEPTH), "result queue overflow")
    `ASSERT_NEXT(a_quiet_beat, quiet_beat, count_reg <= $past(count_reg), "quiet beat queued a rectangle")
    `ASSERT_NEXT(a_done_ends_line, step_go && step_done, finished_reg, "finishing step left line open")
    `ASSERT_IMPLY(a_step_moved, step_go && have_prev_reg, moved_x_reg || moved_y_reg, "pen did not move")
    `ASSERT_IMPLY(a_empty_zeroed, m_valid && !m_data.rect_valid, m_box_zero, "empty rectangle has bounds")

endmodule

### test/tb_thick_line_strip_rasterizer_top.sv
module tb_thick_line_strip_rasterizer_top;
    import tlsr_pkg::*;

    class rect_scoreboard;
        localparam int unsigned SURF_MAX = 4096;

        int unsigned surf_w;
        int unsigned surf_h;

        int          pen_col;
        int          pen_row;
        int          target_col;
        int          target_row;
        int          err_acc;
        int          span_x;
        int          span_y_neg;
        bit          step_left;
        bit          step_up;
        int          pen_side;
        int          prev_l;
        int          prev_t;
        int          prev_r;
        int          prev_b;
        bit          have_prev;
        int unsigned steps_taken;
        bit          line_idle;

        tlsr_out_t   pending_rects[$];
        int          mismatches;
        int          rects_seen;

        function new();
            surf_w      = RST_WIDTH;
            surf_h      = RST_HEIGHT;
            pen_col     = 0;
            pen_row     = 0;
            target_col  = 0;
            target_row  = 0;
            err_acc     = 0;
            span_x      = 0;
            span_y_neg  = 0;
            step_left   = 1'b0;
            step_up     = 1'b0;
            pen_side    = 1;
            prev_l      = 0;
            prev_t      = 0;
            prev_r      = 0;
            prev_b      = 0;
            have_prev   = 1'b0;
            steps_taken = 0;
            line_idle   = 1'b1;
            mismatches  = 0;
            rects_seen  = 0;
        endfunction

        function int unsigned clamp_dim(int unsigned d);
            return (d > SURF_MAX) ? SURF_MAX : d;
        endfunction

        function void set_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
            if (idx == REG_SURFACE_WIDTH) begin
                surf_w = val;
            end else if (idx == REG_SURFACE_HEIGHT) begin
                surf_h = val;
            end
        endfunction

        // Clips an inclusive rectangle to the surface; an empty one comes back all zero.
        function tlsr_out_t clip_rect(int x0, int y0, int x1, int y1);
            tlsr_out_t r;
            int        w;
            int        h;
            int        l;
            int        t;
            int        rt;
            int        b;
            w  = clamp_dim(surf_w);
            h  = clamp_dim(surf_h);
            l  = (x0 < 0) ? 0 : x0;
            t  = (y0 < 0) ? 0 : y0;
            rt = (x1 < w - 1) ? x1 : w - 1;
            b  = (y1 < h - 1) ? y1 : h - 1;
            r  = '0;
            if (l <= rt && t <= b) begin
                r.rect_valid  = 1'b1;
                r.rect_left   = l[OUT_BITS-1:0];
                r.rect_top    = t[OUT_BITS-1:0];
                r.rect_right  = rt[OUT_BITS-1:0];
                r.rect_bottom = b[OUT_BITS-1:0];
            end
            return r;
        endfunction

        function void note_input(tlsr_in_t beat);
            tlsr_out_t   strips[2];
            tlsr_out_t   r;
            int          n;
            int          half;
            int          bx0;
            int          by0;
            int          bx1;
            int          by1;
            int          sx0;
            int          sx1;
            int          dx;
            int          dy;
            int          e2;
            int unsigned guard;
            bit          done;
            if (beat.mode == MODE_LOAD) begin
                pen_col    = $signed(beat.start_x);
                pen_row    = $signed(beat.start_y);
                target_col = $signed(beat.end_x);
                target_row = $signed(beat.end_y);
                dx         = target_col - pen_col;
                dy         = target_row - pen_row;
                span_x     = (dx < 0) ? -dx : dx;
                span_y_neg = (dy < 0) ? dy : -dy;
                step_left  = !(pen_col < target_col);
                step_up    = !(pen_row < target_row);
                err_acc    = span_x + span_y_neg;
                pen_side   = (beat.pen_size < 1) ? 1 : int'(beat.pen_size);
                have_prev  = 1'b0;
                steps_taken = 0;
                line_idle  = 1'b0;
                return;
            end
            if (line_idle) begin
                return;
            end

            half = pen_side / 2;
            bx0  = pen_col - half;
            by0  = pen_row - half;
            bx1  = bx0 + pen_side - 1;
            by1  = by0 + pen_side - 1;
            n    = 0;
            if (!have_prev) begin
                strips[0] = clip_rect(bx0, by0, bx1, by1);
                n = 1;
            end else begin
                // New columns first, then new rows over the columns both blocks share.
                if (bx0 > prev_l) begin
                    strips[n] = clip_rect(prev_r + 1, by0, bx1, by1);
                    n = n + 1;
                end else if (bx0 < prev_l) begin
                    strips[n] = clip_rect(bx0, by0, prev_l - 1, by1);
                    n = n + 1;
                end
                if (by0 != prev_t) begin
                    sx0 = (bx0 > prev_l) ? bx0 : prev_l;
                    sx1 = (bx1 < prev_r) ? bx1 : prev_r;
                    if (sx0 <= sx1) begin
                        if (by0 > prev_t) begin
                            strips[n] = clip_rect(sx0, prev_b + 1, sx1, by1);
                        end else begin
                            strips[n] = clip_rect(sx0, by0, sx1, prev_t - 1);
                        end
                        n = n + 1;
                    end
                end
            end
            prev_l    = bx0;
            prev_t    = by0;
            prev_r    = bx1;
            prev_b    = by1;
            have_prev = 1'b1;

            guard = (clamp_dim(surf_w) + clamp_dim(surf_h)) * 4 + 8;
            done  = (pen_col == target_col && pen_row == target_row) ||
                    (steps_taken + 1 >= guard);
            steps_taken = (steps_taken + 1) & 32'h0000_FFFF;
            if (done) begin
                line_idle = 1'b1;
            end else begin
                e2 = 2 * err_acc;
                if (e2 >= span_y_neg) begin
                    err_acc = err_acc + span_y_neg;
                    pen_col = pen_col + (step_left ? -1 : 1);
                end
                if (e2 <= span_x) begin
                    err_acc = err_acc + span_x;
                    pen_row = pen_row + (step_up ? -1 : 1);
                end
            end

            for (int k = 0; k < n; k++) begin
                r = strips[k];
                r.last_of_step = (k == n - 1);
                r.line_done    = done;
                pending_rects.push_back(r);
            end
        endfunction

        task flag(string msg);
            mismatches++;
            $display("mismatch: %s", msg);
        endtask

        task check_result(tlsr_out_t got);
            tlsr_out_t want;
            string     bad;
            rects_seen++;
            if (pending_rects.size() == 0) begin
                flag($sformatf("rectangle %0d arrived with nothing expected: %h",
                               rects_seen, got));
                return;
            end
            want = pending_rects.pop_front();
            bad  = "";
            if (got.rect_valid !== want.rect_valid)     bad = {bad, " rect_valid"};
            if (got.rect_left !== want.rect_left)       bad = {bad, " rect_left"};
            if (got.rect_top !== want.rect_top)         bad = {bad, " rect_top"};
            if (got.rect_right !== want.rect_right)     bad = {bad, " rect_right"};
            if (got.rect_bottom !== want.rect_bottom)   bad = {bad, " rect_bottom"};
            if (got.last_of_step !== want.last_of_step) bad = {bad, " last_of_step"};
            if (got.line_done !== want.line_done)       bad = {bad, " line_done"};
            if (bad != "") begin
                flag($sformatf("rectangle %0d wrong in%s: got %h expected %h",
                               rects_seen, bad, got, want));
            end
        endtask
    endclass

    localparam int RANDOM_ITEMS   = 1050;
    localparam int N_PHASES       = 8;
    localparam int NO_CUT         = 1 << 30;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 1000;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_addr;
    logic [CFG_BITS-1:0]     cfg_wdata;
    logic                    s_valid;
    logic                    s_ready;
    tlsr_in_t                s_data;
    logic                    m_valid;
    logic                    m_ready;
    tlsr_out_t               m_data;

    rect_scoreboard sb;
    bit             no_idle;
    int             work_items;
    int             quiet_cycles;

    int unsigned phase_w[N_PHASES] = '{1, 8191, 0, 4096, 0, 37, 200, 640};
    int unsigned phase_h[N_PHASES] = '{1, 8191, 0, 4096, 300, 5000, 150, 480};

    thick_line_strip_rasterizer_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            m_ready <= no_idle || ($urandom_range(0, 99) >= 8);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sb.check_result(m_data);
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic tlsr_in_t load_beat(int x0, int y0, int x1, int y1, int pen);
        tlsr_in_t b;
        b.mode     = MODE_LOAD;
        b.start_x  = x0[COORD_BITS-1:0];
        b.start_y  = y0[COORD_BITS-1:0];
        b.end_x    = x1[COORD_BITS-1:0];
        b.end_y    = y1[COORD_BITS-1:0];
        b.pen_size = pen[PEN_BITS-1:0];
        return b;
    endfunction

    // Coordinate and pen fields of a step beat are don't-care, so fill them with noise.
    function automatic tlsr_in_t step_beat();
        tlsr_in_t b;
        b.mode     = MODE_STEP;
        b.start_x  = COORD_BITS'($urandom);
        b.start_y  = COORD_BITS'($urandom);
        b.end_x    = COORD_BITS'($urandom);
        b.end_y    = COORD_BITS'($urandom);
        b.pen_size = PEN_BITS'($urandom);
        return b;
    endfunction

    task automatic send_beat(tlsr_in_t beat);
        if (!no_idle && $urandom_range(0, 99) < 8) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (beat.mode == MODE_LOAD || !sb.line_idle) begin
            work_items++;
        end
        sb.note_input(beat);
    endtask

    task automatic run_line(int x0, int y0, int x1, int y1, int pen, int max_steps);
        int taken;
        taken = 0;
        send_beat(load_beat(x0, y0, x1, y1, pen));
        while (!sb.line_idle && taken < max_steps) begin
            send_beat(step_beat());
            taken++;
        end
    endtask

    // Lowers valid, waits for every rectangle, then lets the pipeline settle.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending_rects.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_surface(int unsigned w, int unsigned h);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_SURFACE_WIDTH;
        cfg_wdata <= w[CFG_BITS-1:0];
        @(posedge aclk);
        sb.set_register(REG_SURFACE_WIDTH, w[CFG_BITS-1:0]);
        cfg_addr  <= REG_SURFACE_HEIGHT;
        cfg_wdata <= h[CFG_BITS-1:0];
        @(posedge aclk);
        sb.set_register(REG_SURFACE_HEIGHT, h[CFG_BITS-1:0]);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_line();
        int w;
        int h;
        int kind;
        int x0;
        int y0;
        int x1;
        int y1;
        int pen;
        int cut;
        w    = sb.clamp_dim(sb.surf_w);
        h    = sb.clamp_dim(sb.surf_h);
        kind = $urandom_range(0, 99);
        pen  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 9);
        cut  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : NO_CUT;
        if (kind < 70) begin
            // Short lines around the surface, crossing its edges now and then.
            x0 = int'($urandom_range(0, w + 40)) - 20;
            y0 = int'($urandom_range(0, h + 40)) - 20;
            x1 = x0 + int'($urandom_range(0, 60)) - 30;
            y1 = y0 + int'($urandom_range(0, 60)) - 30;
        end else if (kind < 85) begin
            // Short lines at the ends of the coordinate range, pointing inward.
            x0 = $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 3))
                                      : -32768 + int'($urandom_range(0, 3));
            y0 = $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 3))
                                      : -32768 + int'($urandom_range(0, 3));
            x1 = x0 + ((x0 > 0) ? -1 : 1) * int'($urandom_range(0, 10));
            y1 = y0 + ((y0 > 0) ? -1 : 1) * int'($urandom_range(0, 10));
        end else begin
            // Arbitrary endpoints; cut short unless the step guard ends the line first.
            x0  = $signed(COORD_BITS'($urandom));
            y0  = $signed(COORD_BITS'($urandom));
            x1  = $signed(COORD_BITS'($urandom));
            y1  = $signed(COORD_BITS'($urandom));
            cut = $urandom_range(1, 24);
        end
        run_line(x0, y0, x1, y1, pen, cut);
        if (sb.line_idle && $urandom_range(0, 7) == 0) begin
            send_beat(step_beat());
        end
    endtask

    initial begin
        int goal;
        aresetn      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_addr     <= REG_SURFACE_WIDTH;
        cfg_wdata    <= '0;
        s_valid      <= 1'b0;
        s_data       <= '0;
        quiet_cycles <= 0;
        no_idle      = 1'b0;
        work_items   = 0;
        sb           = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed lines on the default surface.
        send_beat(step_beat());
        run_line(0, 0, 3, 2, 0, NO_CUT);
        run_line(632, 475, 642, 470, 4, 4);
        run_line(-32768, -32768, 32767, 32767, 255, 2);
        run_line(32767, 32767, 32765, 32766, 255, NO_CUT);
        run_line(5, 100, 5, 97, 2, NO_CUT);
        send_beat(step_beat());

        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            write_surface(phase_w[p], phase_h[p]);
            no_idle = (p == 3);
            goal    = work_items + RANDOM_ITEMS / N_PHASES;
            while (work_items < goal) begin
                random_line();
            end
        end
        drain();
        repeat (8) @(posedge aclk);

        if (sb.mismatches == 0 && sb.pending_rects.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
